// ===== sv/par_pkg.sv =====
// Shared types and constants for the pixel accumulate/resolve block.
// Depends on nothing; every other file but par_ram imports it.
`default_nettype none

package par_pkg;

    // Default sizing of the accumulation buffer
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int SUM_BITS_DEF   = 32;

    // Field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 8;
    localparam int PASS_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int COLOR_W    = 8;

    // Configuration port and register widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SPP_W      = 16;
    localparam int IMG_W_W    = 9;
    localparam int THR_W      = 12;

    // Derived arithmetic widths
    localparam int FRAC_BITS  = 12;                  // Q.12 samples and sums
    localparam int DIV_W      = PASS_W + 1;          // divisor up to 65536
    localparam int TD_W       = THR_W + DIV_W;       // threshold * divisor
    localparam int IDX_W      = COORD_W + IMG_W_W;   // row * width + col
    localparam int ADDR_MAX_W = 24;                  // up to 4096 x 4096 pixels
    localparam int QUOT_W     = COLOR_W;             // quotient bits of the resolve

    // Color limits
    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hff;
    localparam logic [COLOR_W-1:0] COLOR_MIN = 8'h00;

    // Register reset values
    localparam logic [SPP_W-1:0]   SPP_RST    = 16'd1;
    localparam logic               INCR_RST   = 1'b0;
    localparam logic [IMG_W_W-1:0] WIDTH_RST  = 9'd256;
    localparam logic [THR_W-1:0]   THRESH_RST = 12'd1;

    // Operation codes; code 3 has no meaning
    typedef enum logic [OP_W-1:0] {
        OP_ACCUM = 2'd0,
        OP_FINAL = 2'd1,
        OP_PASS  = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPP    = 2'd0,
        CFG_INCR   = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_THRESH = 2'd3
    } cfg_idx_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_UPDATE = 3'd1,
        BK_LOAD   = 3'd2,
        BK_DIVIDE = 3'd3,
        BK_FINISH = 3'd4
    } back_state_t;

    // Classified command handed from the front end to the back end
    typedef struct packed {
        logic                    is_read;
        logic                    out_of_range;
        logic                    overwrite;
        logic [ADDR_MAX_W-1:0]   addr;
        logic [DIV_W-1:0]        divisor;
        logic [TD_W-1:0]         thresh_div;
        logic [SAMPLE_W-1:0]     red;
        logic [SAMPLE_W-1:0]     green;
        logic [SAMPLE_W-1:0]     blue;
    } par_cmd_t;

endpackage

`default_nettype wire

// ===== sv/par_req_if.sv =====
// Request channel: valid/ready handshake carrying one input beat.
// Depends on par_pkg.
`default_nettype none

interface par_req_if;
    import par_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [PASS_W-1:0]   pass_index;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;

    modport source
    (
        output valid, op, col, row, pass_index, red_in, green_in, blue_in,
        input  ready
    );

    modport sink
    (
        input  valid, op, col, row, pass_index, red_in, green_in, blue_in,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/par_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one resolved pixel beat.
// Depends on par_pkg.
`default_nettype none

interface par_rsp_if;
    import par_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;

    modport source
    (
        output valid, red_out, green_out, blue_out,
        input  ready
    );

    modport sink
    (
        input  valid, red_out, green_out, blue_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/par_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module par_ram
#(
    parameter  int WIDTH  = 96,
    parameter  int DEPTH  = 65536,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

// ===== sv/par_front.sv =====
// Front end: accepts request beats, forms the pixel index and divisor,
// drops items that do nothing and pushes the rest into the command queue.
// Depends on par_pkg and par_req_if.
`default_nettype none

module par_front
#(
    parameter int DEPTH = par_pkg::MAX_WIDTH_DEF * par_pkg::MAX_HEIGHT_DEF
)
(
    par_req_if.sink                      req,
    input  logic [par_pkg::SPP_W-1:0]    spp,
    input  logic                         incr,
    input  logic [par_pkg::IMG_W_W-1:0]  width_used,
    input  logic [par_pkg::THR_W-1:0]    thresh,
    input  logic                         q_full,
    output logic                         push,
    output par_pkg::par_cmd_t            push_cmd
);
    import par_pkg::*;

    localparam logic [ADDR_MAX_W:0] DEPTH_C = (ADDR_MAX_W + 1)'(DEPTH);

    logic [IDX_W-1:0]      row_base;
    logic [IDX_W-1:0]      idx;
    logic [ADDR_MAX_W:0]   idx_ext;
    logic                  in_range;
    logic [DIV_W-1:0]      divisor;
    logic                  keep;
    logic                  is_read;

    // Form the linear pixel index and check it against the buffer size
    assign row_base = IDX_W'(req.row) * IDX_W'(width_used);
    assign idx      = row_base + IDX_W'(req.col);
    assign idx_ext  = (ADDR_MAX_W + 1)'(idx);
    assign in_range = idx_ext < DEPTH_C;

    // Classify the operation: keep what produces a write or a result
    always_comb
    begin
        keep    = 1'b0;
        is_read = 1'b0;
        divisor = (spp == '0) ? DIV_W'(1) : DIV_W'(spp);
        unique case (op_t'(req.op))
            OP_ACCUM:
            begin
                keep = in_range;
            end
            OP_FINAL:
            begin
                keep    = 1'b1;
                is_read = 1'b1;
            end
            OP_PASS:
            begin
                keep    = incr;
                is_read = 1'b1;
                divisor = DIV_W'(req.pass_index) + DIV_W'(1);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Build the queue entry
    always_comb
    begin
        push_cmd.is_read      = is_read;
        push_cmd.out_of_range = !in_range;
        push_cmd.overwrite    = (req.pass_index == '0);
        push_cmd.addr         = idx_ext[ADDR_MAX_W-1:0];
        push_cmd.divisor      = divisor;
        push_cmd.thresh_div   = TD_W'(thresh) * TD_W'(divisor);
        push_cmd.red          = req.red_in;
        push_cmd.green        = req.green_in;
        push_cmd.blue         = req.blue_in;
    end

    // Accept whenever the queue has room; dropped beats are simply consumed
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full && keep;
endmodule

`default_nettype wire

// ===== sv/par_cmd_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on par_pkg.
`default_nettype none

module par_cmd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  par_pkg::par_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output par_pkg::par_cmd_t head_cmd
);
    import par_pkg::*;

    localparam int ENTRIES = 2;

    par_cmd_t   entries_reg [ENTRIES];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'(ENTRIES));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

`default_nettype wire

// ===== sv/par_back.sv =====
// Back end: runs queued commands against the sum RAM - saturating
// accumulate, or read plus a bit-serial divide into 8-bit colors.
// Depends on par_pkg and par_rsp_if.
`default_nettype none

module par_back
#(
    parameter  int SUM_BITS = par_pkg::SUM_BITS_DEF,
    parameter  int DEPTH    = par_pkg::MAX_WIDTH_DEF * par_pkg::MAX_HEIGHT_DEF,
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int RAM_W    = 3 * SUM_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  par_pkg::par_cmd_t head_cmd,
    output logic              pop,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [RAM_W-1:0]  ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [RAM_W-1:0]  ram_rdata,
    par_rsp_if.source         rsp
);
    import par_pkg::*;

    localparam int D_W    = DIV_W + FRAC_BITS;
    localparam int DSH_W  = D_W + QUOT_W - 1;
    localparam int NUM_W  = SUM_BITS + QUOT_W;
    localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int SAT_W  = (SUM_BITS > D_W) ? SUM_BITS : D_W;
    localparam int BLK_W  = (SUM_BITS + FRAC_BITS > TD_W) ? SUM_BITS + FRAC_BITS : TD_W;
    localparam int STEP_W = $clog2(QUOT_W);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               load_out;
    par_cmd_t           cur_reg;
    logic [DSH_W-1:0]   dsh_reg;
    logic [D_W-1:0]     dvs_full;

    logic [SAMPLE_W-1:0] smp       [3];
    logic [CMP_W-1:0]    rem_reg   [3];
    logic [QUOT_W-1:0]   quo_reg   [3];
    logic                sat_reg   [3];
    logic                blk_reg   [3];
    logic [COLOR_W-1:0]  color_reg [3];
    logic [COLOR_W-1:0]  result    [3];

    assign smp[0]   = cur_reg.red;
    assign smp[1]   = cur_reg.green;
    assign smp[2]   = cur_reg.blue;
    assign dvs_full = {cur_reg.divisor, {FRAC_BITS{1'b0}}};

    assign ram_raddr = head_cmd.addr[ADDR_W-1:0];
    assign ram_waddr = cur_reg.addr[ADDR_W-1:0];

    // Sequence one command at a time
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head_cmd.is_read)
                    begin
                        ram_re     = !head_cmd.out_of_range;
                        state_next = BK_LOAD;
                    end
                    else
                    begin
                        ram_re     = !head_cmd.overwrite;
                        state_next = BK_UPDATE;
                    end
                end
            end
            BK_UPDATE:
            begin
                ram_we     = 1'b1;
                state_next = BK_IDLE;
            end
            BK_LOAD:
            begin
                step_next  = '0;
                state_next = cur_reg.out_of_range ? BK_FINISH : BK_DIVIDE;
            end
            BK_DIVIDE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUOT_W - 1))
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Hold the result until the sink takes it
    assign out_valid_next = load_out || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Latch the popped command and the shifting divisor
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_cmd;
        end
        if (state_reg == BK_LOAD)
        begin
            dsh_reg <= DSH_W'({dvs_full, {(QUOT_W - 1){1'b0}}});
        end
        else if (state_reg == BK_DIVIDE)
        begin
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Per-channel lanes: saturating add, flags and restoring divide
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic [SUM_BITS-1:0] s_old;
        logic [SUM_BITS:0]   sum_wide;
        logic [SUM_BITS-1:0] upd;
        logic [CMP_W-1:0]    num;
        logic                sat_load;
        logic                blk_load;
        logic                ge;

        assign s_old    = ram_rdata[c * SUM_BITS +: SUM_BITS];

        // Overwrite on pass 0, else add and clamp at the sum maximum
        assign sum_wide = {1'b0, s_old} + (SUM_BITS + 1)'(smp[c]);
        assign upd      = cur_reg.overwrite ? SUM_BITS'(smp[c]) :
                          (sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0]);
        assign ram_wdata[c * SUM_BITS +: SUM_BITS] = upd;

        // Dividend s*255, and the above-one and black checks
        assign num      = CMP_W'({s_old, {QUOT_W{1'b0}}}) - CMP_W'(s_old);
        assign sat_load = SAT_W'(s_old) > SAT_W'(dvs_full);
        assign blk_load = BLK_W'({s_old, {FRAC_BITS{1'b0}}}) <= BLK_W'(cur_reg.thresh_div);

        // One quotient bit per cycle
        assign ge = rem_reg[c] >= CMP_W'(dsh_reg);

        assign result[c] = sat_reg[c] ? COLOR_MAX :
                           (blk_reg[c] ? COLOR_MIN : quo_reg[c]);

        always_ff @(posedge clk)
        begin
            if (state_reg == BK_LOAD)
            begin
                rem_reg[c] <= num;
                quo_reg[c] <= '0;
                sat_reg[c] <= !cur_reg.out_of_range && sat_load;
                blk_reg[c] <= cur_reg.out_of_range || blk_load;
            end
            else if (state_reg == BK_DIVIDE)
            begin
                rem_reg[c] <= ge ? (rem_reg[c] - CMP_W'(dsh_reg)) : rem_reg[c];
                quo_reg[c] <= {quo_reg[c][QUOT_W-2:0], ge};
            end
            if (load_out)
            begin
                color_reg[c] <= result[c];
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.red_out   = color_reg[0];
    assign rsp.green_out = color_reg[1];
    assign rsp.blue_out  = color_reg[2];
endmodule

`default_nettype wire

// ===== sv/pixel_accumulate_resolve.sv =====
// Per-pixel RGB accumulation buffer with an 8-bit resolve. Accumulate beats
// (op 0) take a read of the stored sums and a saturating write, or a
// direct write on pass 0. Resolve beats (op 1, op 2) take an issue, a RAM
// read, 8 steps of a one-bit-per-cycle restoring divider (all three
// channels at once) and a result load; an index outside the buffer skips
// the divider. A two-entry queue lets the request side keep accepting while
// the back end works or a result waits. Beats that do nothing (op 3, op 2
// with incremental mode off, accumulate outside the buffer) are accepted and
// produce nothing. The sum memory is not cleared at reset; a
// pixel must be written on pass 0 before it is read or added to.
// Depends on par_pkg, par_req_if, par_rsp_if and all par_* modules.
`default_nettype none

module pixel_accumulate_resolve
#(
    parameter int MAX_WIDTH  = par_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = par_pkg::MAX_HEIGHT_DEF,
    parameter int SUM_BITS   = par_pkg::SUM_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    par_req_if.sink                         req,
    par_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [par_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [par_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import par_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RAM_W  = 3 * SUM_BITS;

    logic [SPP_W-1:0]   spp_reg;
    logic               incr_reg;
    logic [IMG_W_W-1:0] width_reg;
    logic [THR_W-1:0]   thresh_reg;

    logic               q_push;
    par_cmd_t           q_push_cmd;
    logic               q_full;
    logic               q_pop;
    logic               q_head_valid;
    par_cmd_t           q_head_cmd;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [RAM_W-1:0]   ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg    <= SPP_RST;
            incr_reg   <= INCR_RST;
            width_reg  <= WIDTH_RST;
            thresh_reg <= THRESH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SPP:    spp_reg    <= cfg_data[SPP_W-1:0];
                CFG_INCR:   incr_reg   <= cfg_data[0];
                CFG_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_THRESH: thresh_reg <= cfg_data[THR_W-1:0];
            endcase
        end
    end

    par_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .req        (req),
        .spp        (spp_reg),
        .incr       (incr_reg),
        .width_used (width_reg),
        .thresh     (thresh_reg),
        .q_full     (q_full),
        .push       (q_push),
        .push_cmd   (q_push_cmd)
    );

    par_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    par_back #(
        .SUM_BITS (SUM_BITS),
        .DEPTH    (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .rsp        (rsp)
    );

    par_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A full queue always presents a head entry
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> q_head_valid)
        else $error("queue full without a head entry");

    // The back end never reads and writes the sum RAM in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("sum RAM read and write overlap");

    // Each RAM read belongs to one command: no read in the following cycle
    a_read_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> !ram_re)
        else $error("back-to-back sum RAM reads");

    // A RAM write always directly follows the pop of an accumulate command
    a_write_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> $past(q_pop))
        else $error("sum RAM write without a preceding command pop");
endmodule

`default_nettype wire

// ===== tb/par_resolve_checker.sv =====
// Checker for the pixel accumulate/resolve block: watches request, response and
// register-write traffic, predicts every resolved pixel and compares it.
// Depends on par_pkg, par_req_if and par_rsp_if.

module par_resolve_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    par_req_if                             req,
    par_rsp_if                             rsp,
    input  logic                           cfg_we,
    input  logic [par_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [par_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending,
    output int                             results_seen
);
    import par_pkg::*;

    localparam int          PIXELS     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int          SUM_W      = SUM_BITS_DEF;
    localparam logic [63:0] SUM_LIMIT  = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] ONE_Q12    = 64'd1 << FRAC_BITS;
    localparam int          REPORT_MAX = 10;

    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [2:0][SUM_W-1:0] rgb_sums_t;   // [0] red, [1] green, [2] blue

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb8_t;

    // Own copy of the sum buffer, keyed by pixel index
    rgb_sums_t sum_store [int];
    rgb8_t     expected_pixels [$];

    // Own copy of the register file
    logic [SPP_W-1:0]   spp_reg   = SPP_RST;
    logic               incr_reg  = INCR_RST;
    logic [IMG_W_W-1:0] width_reg = WIDTH_RST;
    logic [THR_W-1:0]   thr_reg   = THRESH_RST;

    int err_total    = 0;
    int result_total = 0;

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
    end

    // Add a sample to a stored sum, pinning at the top of the sum range
    function automatic sum_t saturating_add(sum_t held, logic [SAMPLE_W-1:0] sample);
        logic [63:0] total;
        total = 64'(held) + 64'(sample);
        return (total > SUM_LIMIT) ? sum_t'(SUM_LIMIT) : sum_t'(total);
    endfunction

    // Average one channel by the divisor and map it to 8 bits
    function automatic logic [COLOR_W-1:0] resolve_channel(sum_t sum,
                                                           logic [DIV_W-1:0] div,
                                                           logic [THR_W-1:0] thr);
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] t;
        s = 64'(sum);
        d = 64'(div);
        t = 64'(thr);
        if (s > ONE_Q12 * d)
            return COLOR_MAX;
        if (s * ONE_Q12 <= t * d)
            return COLOR_MIN;
        return COLOR_W'((s * 64'd255) / (ONE_Q12 * d));
    endfunction

    always @(posedge clk)
    begin : watch
        rgb8_t            want;
        rgb8_t            seen;
        rgb_sums_t        held;
        rgb_sums_t        next_sums;
        int               idx;
        logic             in_range;
        logic             emit;
        logic [DIV_W-1:0] divisor;

        if (rst_n)
        begin
            // Compare a response beat with the oldest expected pixel
            if (rsp.valid && rsp.ready)
            begin
                result_total++;
                seen = '{red: rsp.red_out, green: rsp.green_out, blue: rsp.blue_out};
                if (expected_pixels.size() == 0)
                begin
                    err_total++;
                    if (err_total <= REPORT_MAX)
                        $display("%0t: unexpected response %02h %02h %02h",
                                 $time, seen.red, seen.green, seen.blue);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen.red !== want.red || seen.green !== want.green ||
                        seen.blue !== want.blue)
                    begin
                        err_total++;
                        if (err_total <= REPORT_MAX)
                            $display("%0t: expected %02h %02h %02h, got %02h %02h %02h",
                                     $time, want.red, want.green, want.blue,
                                     seen.red, seen.green, seen.blue);
                    end
                end
            end

            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPP:    spp_reg   = cfg_data[SPP_W-1:0];
                    CFG_INCR:   incr_reg  = cfg_data[0];
                    CFG_WIDTH:  width_reg = cfg_data[IMG_W_W-1:0];
                    CFG_THRESH: thr_reg   = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            // Predict the effect of a request beat
            if (req.valid && req.ready)
            begin
                idx      = int'(req.row) * int'(width_reg) + int'(req.col);
                in_range = (idx < PIXELS);
                emit     = 1'b0;
                divisor  = DIV_W'(1);
                held     = (in_range && sum_store.exists(idx)) ? sum_store[idx] : '0;
                case (req.op)
                    OP_ACCUM:
                    begin
                        if (in_range)
                        begin
                            if (req.pass_index == '0)
                            begin
                                next_sums[0] = sum_t'(req.red_in);
                                next_sums[1] = sum_t'(req.green_in);
                                next_sums[2] = sum_t'(req.blue_in);
                            end
                            else
                            begin
                                next_sums[0] = saturating_add(held[0], req.red_in);
                                next_sums[1] = saturating_add(held[1], req.green_in);
                                next_sums[2] = saturating_add(held[2], req.blue_in);
                            end
                            sum_store[idx] = next_sums;
                        end
                    end
                    OP_FINAL:
                    begin
                        emit    = 1'b1;
                        divisor = (spp_reg == '0) ? DIV_W'(1) : DIV_W'(spp_reg);
                    end
                    OP_PASS:
                    begin
                        emit    = incr_reg;
                        divisor = DIV_W'(req.pass_index) + DIV_W'(1);
                    end
                    default: ;
                endcase
                if (emit)
                begin
                    if (in_range)
                    begin
                        want.red   = resolve_channel(held[0], divisor, thr_reg);
                        want.green = resolve_channel(held[1], divisor, thr_reg);
                        want.blue  = resolve_channel(held[2], divisor, thr_reg);
                    end
                    else
                        want = '0;
                    expected_pixels.push_back(want);
                end
            end

            mismatches   <= err_total;
            pending      <= expected_pixels.size();
            results_seen <= result_total;
        end
    end

endmodule

// ===== tb/pixel_accumulate_resolve_tb.sv =====
// Top of the pixel accumulate/resolve testbench: clock, reset, register writes,
// request and response stimulus, and the verdict.
// Depends on par_pkg, par_req_if, par_rsp_if, par_resolve_checker and the block.

module pixel_accumulate_resolve_tb;
    import par_pkg::*;

    localparam int              PIXELS            = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam logic [OP_W-1:0] OP_SPARE          = 2'd3;
    localparam int              CYCLE_LIMIT       = 2_000_000;
    localparam int              DRAIN_CYCLES      = 40;
    localparam int              HOLD_CYCLES       = 300;
    localparam int              SETTING_COUNT     = 6;
    localparam int              BEATS_PER_SETTING = 300;
    localparam int              REPEAT_ADDS       = 24;
    localparam int              RECENT_MAX        = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    par_req_if req_ch();
    par_rsp_if rsp_ch();

    int mismatches;
    int pending;
    int results_seen;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int beats_sent;
    int cycles;
    int cur_width;

    // Pixels written on pass 0 since reset, and a pool of recent coordinates
    bit          filled [int];
    logic [15:0] recent_pixels [$];

    pixel_accumulate_resolve u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    par_resolve_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort on a hung run
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Drive response ready: random stalls, plus long hold-offs on request
    initial
    begin : receiver
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return SAMPLE_W'($urandom_range(4096));
            5, 6:    return SAMPLE_W'($urandom_range(300));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one request beat and hold it until accepted
    task automatic send_beat(input logic [OP_W-1:0]     op,
                             input logic [COORD_W-1:0]  col,
                             input logic [COORD_W-1:0]  row,
                             input logic [PASS_W-1:0]   pass,
                             input logic [SAMPLE_W-1:0] red,
                             input logic [SAMPLE_W-1:0] green,
                             input logic [SAMPLE_W-1:0] blue);
        int idx;
        idx = int'(row) * cur_width + int'(col);
        if (op == OP_ACCUM && pass == '0 && idx < PIXELS)
        begin
            filled[idx] = 1'b1;
            recent_pixels.push_back({row, col});
            if (recent_pixels.size() > RECENT_MAX)
                void'(recent_pixels.pop_front());
        end
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.col        <= col;
        req_ch.row        <= row;
        req_ch.pass_index <= pass;
        req_ch.red_in     <= red;
        req_ch.green_in   <= green;
        req_ch.blue_in    <= blue;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // Drop valid, wait for every expected pixel, then let silent beats finish
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; only call while idle
    task automatic load_settings(input logic [SPP_W-1:0]   spp,
                                 input logic               incr,
                                 input logic [IMG_W_W-1:0] width,
                                 input logic [THR_W-1:0]   thr);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPP;
        cfg_data  <= CFG_DATA_W'(spp);
        @(posedge clk);
        cfg_index <= CFG_INCR;
        cfg_data  <= CFG_DATA_W'(incr);
        @(posedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data  <= CFG_DATA_W'(width);
        @(posedge clk);
        cfg_index <= CFG_THRESH;
        cfg_data  <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_width = int'(width);
        @(posedge clk);
    endtask

    // Mostly operations on recently written pixels, some random coordinates
    task automatic random_beat();
        logic [15:0]     spot;
        logic [OP_W-1:0] op;
        logic [PASS_W-1:0] pass;
        int              pick;
        int              idx;
        pick = $urandom_range(99);
        if (recent_pixels.size() == 0 || $urandom_range(7) == 0)
            spot = 16'($urandom);
        else
            spot = recent_pixels[$urandom_range(recent_pixels.size() - 1)];
        idx = int'(spot[15:8]) * cur_width + int'(spot[7:0]);
        if (pick < 3)
            op = OP_SPARE;
        else if (pick < 48)
            op = OP_ACCUM;
        else if (pick < 85)
            op = OP_FINAL;
        else
            op = OP_PASS;
        case ($urandom_range(5))
            0:       pass = '0;
            1:       pass = '1;
            2:       pass = PASS_W'($urandom);
            default: pass = PASS_W'($urandom_range(15));
        endcase
        // Never read or add to a pixel that has not been written on pass 0
        if (op != OP_SPARE && idx < PIXELS && !filled.exists(idx))
        begin
            op   = OP_ACCUM;
            pass = '0;
        end
        send_beat(op, spot[7:0], spot[15:8], pass, rand_sample(), rand_sample(), rand_sample());
    endtask

    // Edge values, every operation, overwrite, threshold and a long hold-off
    task automatic run_directed();
        send_beat(OP_ACCUM, 8'd0,   8'd0,   16'd0, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_FINAL, 8'd0,   8'd0,   16'd0, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_ACCUM, 8'd255, 8'd255, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_FINAL, 8'd255, 8'd255, 16'd0, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_ACCUM, 8'd1,   8'd0,   16'd0, 16'h1000, 16'h1000, 16'h1001);
        send_beat(OP_FINAL, 8'd1,   8'd0,   16'd0, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_ACCUM, 8'd2,   8'd0,   16'd0, 16'h0001, 16'h0002, 16'h0800);
        send_beat(OP_FINAL, 8'd2,   8'd0,   16'd0, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_ACCUM, 8'd1,   8'd0,   16'hFFFF, 16'h1000, 16'h0000, 16'h0001);
        // Per-pass read with incremental mode off, then the unused code
        send_beat(OP_PASS,  8'd1,   8'd0,   16'd1, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_SPARE, 8'd3,   8'd3,   16'd7, 16'hFFFF, 16'h0000, 16'hFFFF);
        settle();
        load_settings(SPP_RST, 1'b1, WIDTH_RST, THRESH_RST);
        send_beat(OP_PASS,  8'd1,   8'd0,   16'd1, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_PASS,  8'd255, 8'd255, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        // Overwrite on pass 0 after an add
        send_beat(OP_ACCUM, 8'd1,   8'd0,   16'd0, 16'h0010, 16'h0FFF, 16'h1000);
        send_beat(OP_FINAL, 8'd1,   8'd0,   16'd0, 16'h0000, 16'h0000, 16'h0000);
        // Sum right at the black threshold
        send_beat(OP_ACCUM, 8'd0,   8'd0,   16'd1, 16'h0001, 16'h0001, 16'h0002);
        send_beat(OP_PASS,  8'd0,   8'd0,   16'd0, 16'h0000, 16'h0000, 16'h0000);
        // Hold the response side so the block fills and stalls requests
        hold_requests++;
        repeat (8)
            send_beat(OP_FINAL, 8'd255, 8'd255, 16'd0, 16'h0000, 16'h0000, 16'h0000);
        settle();
    endtask

    initial
    begin : stimulus
        int s;
        int n;
        int g;
        int total;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_SPP;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_ACCUM;
        req_ch.col        = '0;
        req_ch.row        = '0;
        req_ch.pass_index = '0;
        req_ch.red_in     = '0;
        req_ch.green_in   = '0;
        req_ch.blue_in    = '0;
        rsp_ch.ready      = 1'b0;
        tx_idle_pct       = 6;
        rx_idle_pct       = 73;
        hold_requests     = 0;
        beats_sent        = 0;
        cur_width         = int'(WIDTH_RST);
        total             = SETTING_COUNT * BEATS_PER_SETTING;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Random part over several register settings
        for (s = 0; s < SETTING_COUNT; s++)
        begin
            case (s)
                0: load_settings(16'd1,     1'b1, 9'd256, 12'd1);
                1: load_settings(16'd4,     1'b1, 9'd37,  12'd100);
                2: load_settings(16'd0,     1'b0, 9'd511, 12'd0);
                3: load_settings(16'd65535, 1'b1, 9'd1,   12'd4095);
                4: load_settings(16'd3,     1'b1, 9'd300, THR_W'($urandom_range(4095)));
                default: load_settings(SPP_W'($urandom_range(1, 16)), 1'b1, 9'd0,
                                       THR_W'($urandom_range(4095)));
            endcase
            if (s == 2)
                hold_requests++;
            for (n = 0; n < BEATS_PER_SETTING; n++)
            begin
                g = s * BEATS_PER_SETTING + n;
                if (g < total / 3)
                begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 73;
                end
                else if (g < (2 * total) / 3)
                begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 6;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                random_beat();
            end
            settle();
        end

        // Pile repeated adds onto one pixel so its final red and green averages clip at full scale
        load_settings(16'd1, 1'b1, 9'd256, 12'd1);
        send_beat(OP_ACCUM, 8'd10, 8'd10, 16'd0, 16'hFFFF, 16'h8000, 16'h0000);
        repeat (REPEAT_ADDS)
            send_beat(OP_ACCUM, 8'd10, 8'd10, 16'd1, 16'hFFFF, 16'h8000, 16'h0000);
        send_beat(OP_PASS,  8'd10, 8'd10, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_FINAL, 8'd10, 8'd10, 16'd0,    16'h0000, 16'h0000, 16'h0000);
        settle();

        $display("Sent %0d request beats over %0d register settings, %0d adds on one pixel.",
                 beats_sent, SETTING_COUNT + 3, REPEAT_ADDS);
        $display("Checked %0d resolved pixels, %0d mismatches, %0d still expected.",
                 results_seen, mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
